// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that ante leads to cons on the next clock edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/blcs_pkg.sv =====
// ----------------------------------------------------------------------------
// blcs_pkg
// Shared widths and defaults for the binary longest common substring unit.
// ----------------------------------------------------------------------------
`default_nettype none

package blcs_pkg;

    localparam int DEF_WIDTH   = 32;
    localparam int IN_FIELD_W  = 32;
    localparam int OUT_VAL_W   = 32;
    localparam int OUT_LEN_W   = 6;
    localparam int IN_TDATA_W  = 2 * IN_FIELD_W;
    localparam int OUT_TDATA_W = ((OUT_VAL_W + OUT_LEN_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== hdl/binary_longest_common_substring_unit.sv =====
// ----------------------------------------------------------------------------
// binary_longest_common_substring_unit
// Longest common bit substring of two numbers, largest value among the ties.
// ----------------------------------------------------------------------------
// Steps: ST_NORM shifts out the leading zeros of both words, ST_ROWS walks the
//   bits of the first, ST_FIN loads the output; the row of run cells advances one bit a cycle.
// Throughput: one word at a time; the next word is taken once the result
//   has moved to the output register.
// Reset: synchronous, active low; clears the sequencer and the output valid.
`default_nettype none

`include "assert_macros.svh"

module binary_longest_common_substring_unit #(
    parameter int WIDTH = blcs_pkg::DEF_WIDTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // first_value [31:0], second_value [63:32]
    input  wire logic [blcs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // best_value [31:0], match_length [37:32], zero fill [39:38]
    output logic [blcs_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

    localparam int LW = $clog2(WIDTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NORM,
        ST_ROWS,
        ST_FIN
    } t_state;

    t_state                          r_state;
    logic [WIDTH-1:0]                r_a;
    logic [WIDTH-1:0]                r_b;
    logic [LW-1:0]                   r_la;
    logic [LW-1:0]                   r_lb;
    logic [WIDTH-1:0]                r_win;
    logic [LW-1:0]                   r_run [WIDTH];
    logic [LW-1:0]                   r_len;
    logic [WIDTH-1:0]                r_best;
    logic                            r_ovalid;
    logic [blcs_pkg::OUT_VAL_W-1:0]  r_obest;
    logic [blcs_pkg::OUT_LEN_W-1:0]  r_olen;

    logic [LW-1:0]                   n_run [WIDTH];
    logic [WIDTH-1:0]                n_win;
    logic [WIDTH-1:0]                in_a;
    logic [WIDTH-1:0]                in_b;
    logic [WIDTH-1:0]                up_mask;
    logic [WIDTH-1:0]                eq_mask;
    logic [WIDTH-1:0]                up_val;
    logic [WIDTH-1:0]                eq_val;
    logic [LW:0]                     len_up;
    logic                            a_done;
    logic                            b_done;
    logic                            hit_up;
    logic                            hit_eq;
    logic                            out_free;

    function automatic logic [WIDTH-1:0] f_mask(input logic [LW:0] len);
        f_mask = ~({WIDTH{1'b1}} << len);
    endfunction

    assign in_a = WIDTH'(s_axis_tdata[blcs_pkg::IN_FIELD_W-1:0]);
    assign in_b = WIDTH'(s_axis_tdata[blcs_pkg::IN_TDATA_W-1:blcs_pkg::IN_FIELD_W]);

    assign a_done   = (r_a == '0) || r_a[WIDTH-1];
    assign b_done   = (r_b == '0) || r_b[WIDTH-1];
    assign n_win    = (r_win << 1) | WIDTH'(r_a[WIDTH-1]);
    assign len_up   = {1'b0, r_len} + (LW+1)'(1);
    assign up_mask  = f_mask(len_up);
    assign eq_mask  = f_mask({1'b0, r_len});
    assign up_val   = n_win & up_mask;
    assign eq_val   = n_win & eq_mask;
    assign out_free = !r_ovalid || m_axis_tready;

    always_comb begin
        for (int k = 0; k < WIDTH; k++) begin
            if ((k < int'(r_lb)) && (r_a[WIDTH-1] == r_b[WIDTH-1-k])) begin
                n_run[k] = ((k == 0) ? '0 : r_run[(k == 0) ? 0 : k-1]) + LW'(1);
            end else begin
                n_run[k] = '0;
            end
        end
    end

    always_comb begin
        hit_up = 1'b0;
        hit_eq = 1'b0;
        for (int k = 0; k < WIDTH; k++) begin
            hit_up = hit_up || ({1'b0, n_run[k]} == len_up);
            hit_eq = hit_eq || ((n_run[k] == r_len) && (r_len != '0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if ((r_state == ST_FIN) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_a     <= in_a;
                        r_b     <= in_b;
                        r_la    <= (in_a == '0) ? '0 : LW'(WIDTH);
                        r_lb    <= (in_b == '0) ? '0 : LW'(WIDTH);
                        r_win   <= '0;
                        r_len   <= '0;
                        r_best  <= '0;
                        for (int k = 0; k < WIDTH; k++) begin
                            r_run[k] <= '0;
                        end
                        r_state <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    if (!a_done) begin
                        r_a  <= r_a << 1;
                        r_la <= r_la - LW'(1);
                    end
                    if (!b_done) begin
                        r_b  <= r_b << 1;
                        r_lb <= r_lb - LW'(1);
                    end
                    if (a_done && b_done) begin
                        r_state <= ((r_la == '0) || (r_lb == '0)) ? ST_FIN : ST_ROWS;
                    end
                end
                ST_ROWS: begin
                    r_a   <= r_a << 1;
                    r_win <= n_win;
                    r_la  <= r_la - LW'(1);
                    for (int k = 0; k < WIDTH; k++) begin
                        r_run[k] <= n_run[k];
                    end
                    if (hit_up) begin
                        r_len  <= r_len + LW'(1);
                        r_best <= up_val;
                    end else if (hit_eq && (eq_val > r_best)) begin
                        r_best <= eq_val;
                    end
                    if (r_la == LW'(1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_obest  <= blcs_pkg::OUT_VAL_W'(r_best);
                        r_olen   <= blcs_pkg::OUT_LEN_W'(r_len);
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = blcs_pkg::OUT_TDATA_W'({r_olen, r_obest});

    `ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_state == ST_NORM, "accepted word did not start normalising")
    `ASSERT_CLK(a_len_bound, i_clk, i_rst_n, ({1'b0, r_len} <= (LW+1)'(WIDTH)), "match length beyond width")
    `ASSERT_CLK(a_zero_len_zero_val, i_clk, i_rst_n, !(r_ovalid && (r_olen == '0)) || (r_obest == '0), "empty match with non-zero value")
    `ASSERT_NEXT(a_fin_loads_out, i_clk, i_rst_n, (r_state == ST_FIN) && out_free, r_ovalid && (r_state == ST_IDLE), "finished result not presented")

endmodule

`default_nettype wire
